>>> rtl/core/ap3wr_pkg.sv
package ap3wr_pkg;

   localparam int MAX_EXTENT_DEF = 4096;

   localparam int IDX_W   = 12;
   localparam int BYTE_W  = 8;
   localparam int START_W = IDX_W + BYTE_W;
   localparam int CNT_W   = START_W + 2;
   localparam int MAG_W   = CNT_W - 1;
   localparam int PROD_W  = 26;
   localparam int DIV_W   = PROD_W + 1;
   localparam int Q_W     = 12;
   localparam int EXP_W   = 5;
   localparam int HALF_W  = 16;

   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = Q_W / DIV_STEPS;
   localparam int LATENCY    = 5 + DIV_STAGES + 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 36;

   localparam logic [PROD_W-1:0] PROD_SAT   = PROD_W'(1) << (PROD_W - 1);
   localparam logic [PROD_W-1:0] SMALL_MAX  = PROD_W'(16384);

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_KERNEL    = 3'd0,
      REG_STRIDE    = 3'd1,
      REG_PAD_FRONT = 3'd2,
      REG_PAD_BACK  = 3'd3,
      REG_INPUT     = 3'd4,
      REG_MODE      = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [BYTE_W-1:0] kernel;
      logic [BYTE_W-1:0] stride;
      logic [BYTE_W-1:0] pad_front;
      logic [BYTE_W-1:0] pad_back;
      logic [IDX_W-1:0]  extent;
      logic              incl;
   } axis_cfg_type;

   typedef struct packed {
      logic              zero;
      logic              neg;
      logic [EXP_W-1:0]  expo;
      logic [PROD_W-1:0] dvsr;
      logic [DIV_W-1:0]  rem;
      logic [Q_W-1:0]    quo;
   } div_type;

endpackage

>>> rtl/core/avgpool3d_window_reciprocal.sv
// An accepted req beat passes the axis, magnitude, product, normalise, divider and output registers to its rsp beat.
// Throughput: one beat per cycle; the whole pipeline holds while rsp is stalled.
// The 12-bit quotient is formed by six divider stages of two bits each.
// Reset (synchronous, active high) clears valid bits and loads the default
// window registers: 1x1x1 kernel and stride, no pads, 1x1x1 input, pads included.
module avgpool3d_window_reciprocal #(
   parameter int MAX_EXTENT = ap3wr_pkg::MAX_EXTENT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // out_depth_index, out_height_index, out_width_index, zero fill
   input  logic [39:0]                          req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // recip_half
   output logic [15:0]                          rsp_tdata,
   // zero_window
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [ap3wr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ap3wr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LAT = ap3wr_pkg::LATENCY;
   localparam int CW  = ap3wr_pkg::CNT_W;
   localparam int MW  = ap3wr_pkg::MAG_W;
   localparam int PW  = ap3wr_pkg::PROD_W;

   logic [23:0] kernel_ff, stride_ff, pad_front_ff, pad_back_ff;
   logic [35:0] input_ff;
   logic        mode_ff;
   logic [LAT-1:0] vld_ff, vld_in;
   logic ce;

   ap3wr_pkg::axis_cfg_type cfg_d, cfg_h, cfg_w;
   logic signed [CW-1:0] cnt_d, cnt_h, cnt_w;

   logic [MW-1:0] mag_d_ff, mag_h_ff, mag_w_ff;
   logic          neg_s3_ff, zero_s3_ff;
   logic [PW-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [MW-1:0] mag_w2_ff;
   logic          neg_s4_ff, zero_s4_ff, neg_s5_ff, zero_s5_ff;
   logic [2*MW-1:0]    p1_full;
   logic [PW+MW-1:0]   p2_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff    <= 24'h010101;
         stride_ff    <= 24'h010101;
         pad_front_ff <= '0;
         pad_back_ff  <= '0;
         input_ff     <= 36'h001001001;
         mode_ff      <= 1'b1;
      end else if (csr_we) begin
         case (ap3wr_pkg::reg_idx_type'(csr_addr))
            ap3wr_pkg::REG_KERNEL:    kernel_ff    <= csr_wdata[23:0];
            ap3wr_pkg::REG_STRIDE:    stride_ff    <= csr_wdata[23:0];
            ap3wr_pkg::REG_PAD_FRONT: pad_front_ff <= csr_wdata[23:0];
            ap3wr_pkg::REG_PAD_BACK:  pad_back_ff  <= csr_wdata[23:0];
            ap3wr_pkg::REG_INPUT:     input_ff     <= csr_wdata;
            ap3wr_pkg::REG_MODE:      mode_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign ce         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = ce;
   assign vld_in     = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      cfg_d = '{kernel_ff[23:16], stride_ff[23:16], pad_front_ff[23:16],
                pad_back_ff[23:16], input_ff[35:24], mode_ff};
      cfg_h = '{kernel_ff[15:8], stride_ff[15:8], pad_front_ff[15:8],
                pad_back_ff[15:8], input_ff[23:12], mode_ff};
      cfg_w = '{kernel_ff[7:0], stride_ff[7:0], pad_front_ff[7:0],
                pad_back_ff[7:0], input_ff[11:0], mode_ff};
   end

   ap3wr_axis #(.MAX_EXTENT(MAX_EXTENT)) u_axis_d (
      .clock (clock), .ce (ce), .idx (req_tdata[11:0]), .cfg (cfg_d), .cnt (cnt_d)
   );
   ap3wr_axis #(.MAX_EXTENT(MAX_EXTENT)) u_axis_h (
      .clock (clock), .ce (ce), .idx (req_tdata[23:12]), .cfg (cfg_h), .cnt (cnt_h)
   );
   ap3wr_axis #(.MAX_EXTENT(MAX_EXTENT)) u_axis_w (
      .clock (clock), .ce (ce), .idx (req_tdata[35:24]), .cfg (cfg_w), .cnt (cnt_w)
   );

   always_comb begin
      p1_full = mag_d_ff * mag_h_ff;
      p1_in   = (p1_full >= (2*MW)'(ap3wr_pkg::PROD_SAT)) ? ap3wr_pkg::PROD_SAT
                                                          : PW'(p1_full);
      p2_full = p1_ff * mag_w2_ff;
      p2_in   = (p2_full >= (PW+MW)'(ap3wr_pkg::PROD_SAT)) ? ap3wr_pkg::PROD_SAT
                                                           : PW'(p2_full);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         mag_d_ff   <= cnt_d[CW-1] ? MW'(-cnt_d) : MW'(cnt_d);
         mag_h_ff   <= cnt_h[CW-1] ? MW'(-cnt_h) : MW'(cnt_h);
         mag_w_ff   <= cnt_w[CW-1] ? MW'(-cnt_w) : MW'(cnt_w);
         neg_s3_ff  <= cnt_d[CW-1] ^ cnt_h[CW-1] ^ cnt_w[CW-1];
         zero_s3_ff <= (cnt_d == '0) || (cnt_h == '0) || (cnt_w == '0);
         p1_ff      <= p1_in;
         mag_w2_ff  <= mag_w_ff;
         neg_s4_ff  <= neg_s3_ff;
         zero_s4_ff <= zero_s3_ff;
         p2_ff      <= p2_in;
         neg_s5_ff  <= neg_s4_ff;
         zero_s5_ff <= zero_s4_ff;
      end
   end

   ap3wr_recip u_recip (
      .clock       (clock),
      .ce          (ce),
      .prod        (p2_ff),
      .zero        (zero_s5_ff),
      .neg         (neg_s5_ff),
      .recip_half  (rsp_tdata),
      .zero_window (rsp_tuser)
   );

   assign rsp_tvalid = vld_ff[LAT-1];

   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 16'h0000)
      else $error("zero window with nonzero reciprocal");

   a_at_most_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[14:0] <= 15'h3C00)
      else $error("reciprocal magnitude above one");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted beat lost at pipeline entry");

endmodule

>>> rtl/core/ap3wr_axis.sv
module ap3wr_axis #(
   parameter int MAX_EXTENT = ap3wr_pkg::MAX_EXTENT_DEF
) (
   input  logic                                  clock,
   input  logic                                  ce,
   input  logic [ap3wr_pkg::IDX_W-1:0]           idx,
   input  ap3wr_pkg::axis_cfg_type               cfg,
   output logic signed [ap3wr_pkg::CNT_W-1:0]    cnt
);

   localparam int IW = ap3wr_pkg::IDX_W;
   localparam int SW = ap3wr_pkg::START_W;
   localparam int CW = ap3wr_pkg::CNT_W;
   localparam int BW = ap3wr_pkg::BYTE_W;
   localparam logic [IW-1:0] SAT_MAX =
      (MAX_EXTENT > (1 << IW)) ? {IW{1'b1}} : IW'(MAX_EXTENT - 1);

   logic [SW-1:0]        start_ff, start_in;
   logic signed [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0]        idx_sat, ext_sat;
   logic signed [CW-1:0] s_start, s_k, s_pf, s_pb, s_in, s_len, s_end, s_lim, hi, lo;

   always_comb begin
      idx_sat  = (idx > SAT_MAX) ? SAT_MAX : idx;
      start_in = SW'(idx_sat) * SW'(cfg.stride);
   end

   always_comb begin
      ext_sat = (cfg.extent > SAT_MAX) ? SAT_MAX : cfg.extent;
      s_start = $signed({{(CW-SW){1'b0}}, start_ff});
      s_k     = $signed({{(CW-BW){1'b0}}, cfg.kernel});
      s_pf    = $signed({{(CW-BW){1'b0}}, cfg.pad_front});
      s_pb    = $signed({{(CW-BW){1'b0}}, cfg.pad_back});
      s_in    = $signed({{(CW-IW){1'b0}}, ext_sat});
      s_len   = s_in + s_pf + s_pb;
      s_end   = s_start + s_k;
      s_lim   = s_pf + s_in;
      hi      = (s_end < s_lim) ? s_end : s_lim;
      lo      = (s_pf > s_start) ? s_pf : s_start;
      if (cfg.incl) begin
         cnt_in = (s_end <= s_len) ? s_k : (s_len - s_start);
      end else begin
         cnt_in = hi - lo;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         start_ff <= start_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign cnt = cnt_ff;

endmodule

>>> rtl/core/ap3wr_div_step.sv
module ap3wr_div_step (
   input  logic                clock,
   input  logic                ce,
   input  ap3wr_pkg::div_type  d_in,
   output ap3wr_pkg::div_type  d_out
);

   localparam int DW = ap3wr_pkg::DIV_W;
   localparam int QW = ap3wr_pkg::Q_W;

   ap3wr_pkg::div_type d_ff, d_in_w;
   logic [DW-1:0] r2;

   always_comb begin
      d_in_w = d_in;
      r2     = '0;
      for (int s = 0; s < ap3wr_pkg::DIV_STEPS; s++) begin
         r2 = {d_in_w.rem[DW-2:0], 1'b0};
         if (r2 >= {1'b0, d_in_w.dvsr}) begin
            d_in_w.rem = r2 - {1'b0, d_in_w.dvsr};
            d_in_w.quo = {d_in_w.quo[QW-2:0], 1'b1};
         end else begin
            d_in_w.rem = r2;
            d_in_w.quo = {d_in_w.quo[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         d_ff <= d_in_w;
      end
   end

   assign d_out = d_ff;

endmodule

>>> rtl/core/ap3wr_recip.sv
module ap3wr_recip (
   input  logic                                 clock,
   input  logic                                 ce,
   input  logic [ap3wr_pkg::PROD_W-1:0]         prod,
   input  logic                                 zero,
   input  logic                                 neg,
   output logic [ap3wr_pkg::HALF_W-1:0]         recip_half,
   output logic                                 zero_window
);

   localparam int PW = ap3wr_pkg::PROD_W;
   localparam int DW = ap3wr_pkg::DIV_W;
   localparam int EW = ap3wr_pkg::EXP_W;
   localparam int HW = ap3wr_pkg::HALF_W;
   localparam int NS = ap3wr_pkg::DIV_STAGES;

   ap3wr_pkg::div_type norm_ff, norm_in;
   ap3wr_pkg::div_type chain [NS+1];
   logic [3:0]    e;
   logic          pow2;
   logic [HW-1:0] half_ff, half_in;
   logic          zero_ff;
   logic [DW-1:0] r2;
   logic          up;
   logic [HW-2:0] mag;

   always_comb begin
      e = '0;
      for (int i = 0; i < 15; i++) begin
         if (prod[i]) begin
            e = 4'(i);
         end
      end
      pow2 = (prod == (PW'(1) << e));
      norm_in.zero = zero;
      norm_in.neg  = neg;
      norm_in.quo  = '0;
      if (prod > ap3wr_pkg::SMALL_MAX) begin
         norm_in.dvsr = prod;
         norm_in.expo = '0;
         norm_in.rem  = DW'(1) << 12;
      end else begin
         norm_in.dvsr = prod << (4'd14 - e);
         norm_in.expo = pow2 ? EW'(4'd14 - e) : EW'(4'd13 - e);
         norm_in.rem  = pow2 ? (DW'(1) << 12) : (DW'(1) << 13);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         norm_ff <= norm_in;
      end
   end

   assign chain[0] = norm_ff;

   for (genvar g = 0; g < NS; g++) begin : g_div
      ap3wr_div_step u_step (
         .clock (clock),
         .ce    (ce),
         .d_in  (chain[g]),
         .d_out (chain[g+1])
      );
   end

   always_comb begin
      r2  = {chain[NS].rem[DW-2:0], 1'b0};
      up  = (r2 > {1'b0, chain[NS].dvsr}) ||
            ((r2 == {1'b0, chain[NS].dvsr}) && chain[NS].quo[0]);
      mag = {chain[NS].expo, 10'b0} + (HW-1)'(chain[NS].quo) + (HW-1)'(up);
      half_in = chain[NS].zero ? '0 : {chain[NS].neg, mag};
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         half_ff <= half_in;
         zero_ff <= chain[NS].zero;
      end
   end

   assign recip_half  = half_ff;
   assign zero_window = zero_ff;

endmodule
